// ===== hdl/flss_pkg.sv =====
package flss_pkg;

	localparam int SLOTS      = 16;
	localparam int ENTRY_BITS = 64;
	localparam int SLOT_W     = 4;
	localparam int DATA_W     = 64;
	localparam int CNT_W      = $clog2(SLOTS + 1);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

// ===== hdl/flss_ctrl.sv =====
module flss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output flss_pkg::cmd_t  cmd
);

	flss_pkg::state_t state_q;
	flss_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flss_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			flss_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = flss_pkg::S_EXEC;
				end
			end
			flss_pkg::S_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
				state_d  = flss_pkg::S_IDLE;
			end
			default: begin
				state_d = flss_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/flss_dp.sv =====
module flss_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  flss_pkg::cmd_t                cmd,
	input  logic                          kind,
	input  logic [flss_pkg::SLOT_W-1:0]   slot_in,
	input  logic [flss_pkg::DATA_W-1:0]   data_in,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [flss_pkg::SLOT_W-1:0]   slot_out,
	output logic [flss_pkg::DATA_W-1:0]   data_out
);

	logic [flss_pkg::ENTRY_BITS-1:0] payload_mem [flss_pkg::SLOTS];
	logic [flss_pkg::ENTRY_BITS-1:0] rd_q;

	logic [flss_pkg::SLOT_W-1:0] link_q [flss_pkg::SLOTS];
	logic [flss_pkg::SLOTS-1:0]  in_use_q;
	logic [flss_pkg::SLOT_W-1:0] head_q;
	logic [flss_pkg::SLOT_W-1:0] tail_q;
	logic [flss_pkg::CNT_W-1:0]  count_q;

	logic                          kind_q;
	logic [flss_pkg::SLOT_W-1:0]   slot_q;
	logic [flss_pkg::ENTRY_BITS-1:0] data_q;

	logic                          done_q;
	flss_pkg::status_t             status_q;
	logic [flss_pkg::SLOT_W-1:0]   slot_out_q;
	logic [flss_pkg::DATA_W-1:0]   data_out_q;

	logic empty;
	logic slot_ok;
	logic do_alloc;
	logic do_free;

	assign empty   = (count_q == '0);
	assign slot_ok = (flss_pkg::CNT_W'(slot_q) < flss_pkg::CNT_W'(flss_pkg::SLOTS))
		&& in_use_q[slot_q];
	assign do_alloc = cmd.exec && (kind_q == flss_pkg::KIND_ALLOC) && !empty;
	assign do_free  = cmd.exec && (kind_q == flss_pkg::KIND_FREE) && slot_ok;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			slot_q <= slot_in;
			data_q <= data_in[flss_pkg::ENTRY_BITS-1:0];
			rd_q   <= payload_mem[slot_in];
		end
		if (do_alloc) begin
			payload_mem[head_q] <= data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < flss_pkg::SLOTS; i++) begin
				link_q[i] <= flss_pkg::SLOT_W'((i + 1) % flss_pkg::SLOTS);
			end
			in_use_q <= '0;
			head_q   <= '0;
			tail_q   <= flss_pkg::SLOT_W'(flss_pkg::SLOTS - 1);
			count_q  <= flss_pkg::CNT_W'(flss_pkg::SLOTS);
		end else begin
			if (do_alloc) begin
				in_use_q[head_q] <= 1'b1;
				head_q           <= link_q[head_q];
				count_q          <= count_q - 1'b1;
			end else if (do_free) begin
				if (empty) begin
					head_q <= slot_q;
				end else begin
					link_q[tail_q] <= slot_q;
				end
				tail_q           <= slot_q;
				in_use_q[slot_q] <= 1'b0;
				count_q          <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q   <= flss_pkg::ST_OK;
			slot_out_q <= '0;
			data_out_q <= '0;
			if (kind_q == flss_pkg::KIND_ALLOC) begin
				if (empty) begin
					status_q <= flss_pkg::ST_FULL;
				end else begin
					slot_out_q <= head_q;
				end
			end else begin
				if (!slot_ok) begin
					status_q <= flss_pkg::ST_BAD;
				end else begin
					data_out_q <= flss_pkg::DATA_W'(rd_q);
				end
			end
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign slot_out = slot_out_q;
	assign data_out = data_out_q;

endmodule

// ===== hdl/free_list_slot_store.sv =====
// A result strobes on done once start is taken: the word is loaded, executed while busy, then done is registered.
// A new word is not taken in the execute cycle, which reads and writes the
// link, use and payload state at the list head or tail, and busy is high there.
// done cannot be held off by the receiver.
// Reset: asynchronous; every slot free, each linked to the next, head 0, tail last.
module free_list_slot_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [flss_pkg::SLOT_W-1:0]   slot_in,
	input  logic [flss_pkg::DATA_W-1:0]   data_in,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [flss_pkg::SLOT_W-1:0]   slot_out,
	output logic [flss_pkg::DATA_W-1:0]   data_out
);

	flss_pkg::cmd_t cmd;

	flss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	flss_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.kind     (kind),
		.slot_in  (slot_in),
		.data_in  (data_in),
		.done     (done),
		.status   (status),
		.slot_out (slot_out),
		.data_out (data_out)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_exec_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && done)
		else $error("execute cycle not followed by result");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without execute cycle");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != 2'(flss_pkg::ST_OK)) |-> slot_out == '0 && data_out == '0)
		else $error("failed result carries nonzero fields");

endmodule

// ===== test/tb_free_list_slot_store.sv =====
`timescale 1ns / 1ps

module tb_free_list_slot_store;
	import flss_pkg::*;

	localparam int                IDLE_LIMIT = 400;
	localparam logic [DATA_W-1:0] DATA_MASK  = {DATA_W{1'b1}} >> (DATA_W - ENTRY_BITS);

	typedef struct {
		status_t             st;
		logic [SLOT_W-1:0]   slot;
		logic [DATA_W-1:0]   data;
	} reply_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                kind;
	logic [SLOT_W-1:0]   slot_in;
	logic [DATA_W-1:0]   data_in;
	logic                done;
	logic [1:0]          status;
	logic [SLOT_W-1:0]   slot_out;
	logic [DATA_W-1:0]   data_out;

	logic [DATA_W-1:0]   stored [SLOTS];
	logic [SLOT_W-1:0]   link [SLOTS];
	logic                used [SLOTS];
	logic [SLOT_W-1:0]   free_head;
	logic [SLOT_W-1:0]   free_tail;
	logic [CNT_W-1:0]    free_cnt;

	reply_t              replies_due [$];
	int                  errors;
	int                  quiet_cycles;

	free_list_slot_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.kind     (kind),
		.slot_in  (slot_in),
		.data_in  (data_in),
		.done     (done),
		.status   (status),
		.slot_out (slot_out),
		.data_out (data_out)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [DATA_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic void reset_pool();
		for (int i = 0; i < SLOTS; i++) begin
			stored[i] = '0;
			link[i]   = SLOT_W'((i + 1) % SLOTS);
			used[i]   = 1'b0;
		end
		free_head = '0;
		free_tail = SLOT_W'(SLOTS - 1);
		free_cnt  = CNT_W'(SLOTS);
	endfunction

	function automatic reply_t apply_to_pool(logic k, logic [SLOT_W-1:0] s,
			logic [DATA_W-1:0] d);
		reply_t r;
		r.st   = ST_OK;
		r.slot = '0;
		r.data = '0;
		if (k == KIND_ALLOC) begin
			if (free_cnt == 0) begin
				r.st = ST_FULL;
			end else begin
				stored[free_head] = d & DATA_MASK;
				used[free_head]   = 1'b1;
				r.slot            = free_head;
				free_head         = link[free_head];
				free_cnt          = free_cnt - 1'b1;
			end
		end else if (int'(s) >= SLOTS || !used[s]) begin
			r.st = ST_BAD;
		end else begin
			if (free_cnt == 0) begin
				free_head = s;
			end else begin
				link[free_tail] = s;
			end
			free_tail = s;
			used[s]   = 1'b0;
			free_cnt  = free_cnt + 1'b1;
			r.data    = stored[s] & DATA_MASK;
		end
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] pick_used_slot();
		int cand [$];
		for (int i = 0; i < SLOTS; i++)
			if (used[i])
				cand.push_back(i);
		if (cand.size() == 0)
			return SLOT_W'($urandom_range(0, SLOTS - 1));
		return SLOT_W'(cand[$urandom_range(0, cand.size() - 1)]);
	endfunction

	task automatic report_error(string msg);
		$display("%0t ERROR: %s", $time, msg);
		errors++;
	endtask

	task automatic send_word(logic k, logic [SLOT_W-1:0] s, logic [DATA_W-1:0] d);
		start   <= 1'b1;
		kind    <= k;
		slot_in <= s;
		data_in <= d;
		do
			@(posedge clk);
		while (busy);
		replies_due.push_back(apply_to_pool(k, s, d));
	endtask

	task automatic idle_gap(bit allow);
		int n;
		if (allow && $urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, 14);
			start <= 1'b0;
			repeat (n) begin
				kind    <= 1'($urandom_range(0, 1));
				slot_in <= SLOT_W'($urandom_range(0, SLOTS - 1));
				data_in <= rand_word();
				@(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_fill_pool();
		logic [DATA_W-1:0] pat [4];
		pat[0] = '0;
		pat[1] = '1;
		pat[2] = {(DATA_W / 2){2'b01}};
		pat[3] = {(DATA_W / 2){2'b10}};
		for (int i = 0; i < SLOTS; i++) begin
			send_word(KIND_ALLOC, SLOT_W'($urandom_range(0, SLOTS - 1)),
				i < 4 ? pat[i] : rand_word());
			idle_gap(1'b1);
		end
	endtask

	task automatic test_full_pool();
		send_word(KIND_ALLOC, '1, '1);
		idle_gap(1'b1);
	endtask

	task automatic test_retrieve_when_full();
		send_word(KIND_FREE, SLOT_W'(7), '1);
		send_word(KIND_FREE, SLOT_W'(7), '0);
		send_word(KIND_ALLOC, '0, rand_word());
		send_word(KIND_ALLOC, '0, '0);
		idle_gap(1'b1);
	endtask

	task automatic test_bad_retrieve();
		send_word(KIND_FREE, '0, rand_word());
		send_word(KIND_FREE, '1, rand_word());
		send_word(KIND_FREE, '0, '1);
		send_word(KIND_FREE, '1, '0);
		idle_gap(1'b1);
	endtask

	task automatic test_mixed_traffic(int count, bit allow_idle);
		bit filling;
		bit idle_on;
		logic k;
		logic [SLOT_W-1:0] s;
		filling = 1'b0;
		idle_on = allow_idle;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				filling = ~filling;
				idle_on = allow_idle && $urandom_range(0, 3) != 0;
			end
			if (filling)
				k = $urandom_range(0, 9) < 7 ? KIND_ALLOC : KIND_FREE;
			else
				k = $urandom_range(0, 9) < 7 ? KIND_FREE : KIND_ALLOC;
			if (k == KIND_FREE && $urandom_range(0, 99) < 85)
				s = pick_used_slot();
			else
				s = SLOT_W'($urandom_range(0, SLOTS - 1));
			send_word(k, s, rand_word());
			idle_gap(idle_on);
		end
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 6; i++)
			send_word(KIND_ALLOC, '0, rand_word());
		wait_drained();
		send_word(KIND_FREE, pick_used_slot(), rand_word());
		wait_drained();
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				report_error($sformatf("unexpected result status=%0d slot=%0d data=%h",
					status, slot_out, data_out));
			end else begin
				want = replies_due.pop_front();
				if (status !== want.st)
					report_error($sformatf("status got %0d expected %0d",
						status, want.st));
				if (slot_out !== want.slot)
					report_error($sformatf("slot_out got %0d expected %0d",
						slot_out, want.slot));
				if (data_out !== want.data)
					report_error($sformatf("data_out got %h expected %h",
						data_out, want.data));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		errors       = 0;
		quiet_cycles = 0;
		reset_pool();
		arst_n  <= 1'b0;
		start   <= 1'b0;
		kind    <= KIND_ALLOC;
		slot_in <= '0;
		data_in <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_pool();
		test_full_pool();
		test_retrieve_when_full();
		test_bad_retrieve();
		test_mixed_traffic(250, 1'b1);
		test_drain_pause();
		test_mixed_traffic(250, 1'b1);
		test_mixed_traffic(130, 1'b0);

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
